### hw/rtl/viar_pkg.sv
`default_nettype none

package viar_pkg;

    // Operation carried in tuser of the input channel
    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_TICK  = 3'd2,
        OP_CA1   = 3'd3,
        OP_CB1   = 3'd4
    } op_t;

    // Register map
    localparam logic [3:0] REG_ORB    = 4'd0;
    localparam logic [3:0] REG_ORA    = 4'd1;
    localparam logic [3:0] REG_DDRB   = 4'd2;
    localparam logic [3:0] REG_DDRA   = 4'd3;
    localparam logic [3:0] REG_T1CL   = 4'd4;
    localparam logic [3:0] REG_T1CH   = 4'd5;
    localparam logic [3:0] REG_T1LL   = 4'd6;
    localparam logic [3:0] REG_T1LH   = 4'd7;
    localparam logic [3:0] REG_T2CL   = 4'd8;
    localparam logic [3:0] REG_T2CH   = 4'd9;
    localparam logic [3:0] REG_SR     = 4'd10;
    localparam logic [3:0] REG_ACR    = 4'd11;
    localparam logic [3:0] REG_PCR    = 4'd12;
    localparam logic [3:0] REG_IFR    = 4'd13;
    localparam logic [3:0] REG_IER    = 4'd14;
    localparam logic [3:0] REG_ORA_NH = 4'd15;

    // Interrupt flag masks
    localparam logic [6:0] FLAG_CA2 = 7'h01;
    localparam logic [6:0] FLAG_CA1 = 7'h02;
    localparam logic [6:0] FLAG_SR  = 7'h04;
    localparam logic [6:0] FLAG_CB2 = 7'h08;
    localparam logic [6:0] FLAG_CB1 = 7'h10;
    localparam logic [6:0] FLAG_T2  = 7'h20;
    localparam logic [6:0] FLAG_T1  = 7'h40;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        op_t        operation;
        logic [3:0] reg_address;
        logic [7:0] write_data;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_drive;
        logic [7:0] port_a_enable;
        logic [7:0] port_b_drive;
        logic [7:0] port_b_enable;
        logic       irq_out;
    } result_t;

    // Handshake between the input register and the rest of the pipe
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/viar_in_stage.sv
`default_nettype none

module viar_in_stage (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // reg_address[3:0], write_data[11:4], port_a_pins[19:12], port_b_pins[27:20]
    input  wire logic [viar_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation[2:0]
    input  wire logic [viar_pkg::IN_USER_W-1:0]      s_tuser,
    input  wire logic                                downstream_free,
    output viar_pkg::stage_ctrl_t                    ctrl,
    output viar_pkg::in_item_t                       item
);
    import viar_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign ctrl.valid   = valid_reg;
    assign ctrl.advance = valid_reg && downstream_free;
    assign s_tready     = !valid_reg || downstream_free;
    assign take         = s_tvalid && s_tready;
    assign item         = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (ctrl.advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.operation   <= op_t'(s_tuser);
            item_reg.reg_address <= s_tdata[3:0];
            item_reg.write_data  <= s_tdata[11:4];
            item_reg.port_a_pins <= s_tdata[19:12];
            item_reg.port_b_pins <= s_tdata[27:20];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/viar_core.sv
`default_nettype none

module viar_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire viar_pkg::stage_ctrl_t ctrl,
    input  wire viar_pkg::in_item_t    item,
    output viar_pkg::result_t          result
);
    import viar_pkg::*;

    logic [7:0]  ora_reg, ora_next;
    logic [7:0]  orb_reg, orb_next;
    logic [7:0]  ddra_reg, ddra_next;
    logic [7:0]  ddrb_reg, ddrb_next;
    logic [7:0]  latch_a_reg, latch_a_next;
    logic [7:0]  latch_b_reg, latch_b_next;
    logic [15:0] t1_count_reg, t1_count_next;
    logic [15:0] t1_reload_reg, t1_reload_next;
    logic        t1_active_reg, t1_active_next;
    logic [15:0] t2_count_reg, t2_count_next;
    logic [15:0] t2_reload_reg, t2_reload_next;
    logic        t2_active_reg, t2_active_next;
    logic [7:0]  sr_reg, sr_next;
    logic [7:0]  acr_reg, acr_next;
    logic [7:0]  pcr_reg, pcr_next;
    logic [6:0]  ifr_reg, ifr_next;
    logic [6:0]  ier_reg, ier_next;

    logic [7:0]  rd;
    logic [7:0]  pa_val;
    logic [7:0]  pb_in;

    assign pa_val = acr_reg[0] ? latch_a_reg : item.port_a_pins;
    assign pb_in  = acr_reg[1] ? latch_b_reg : item.port_b_pins;

    always_comb begin
        ora_next       = ora_reg;
        orb_next       = orb_reg;
        ddra_next      = ddra_reg;
        ddrb_next      = ddrb_reg;
        latch_a_next   = latch_a_reg;
        latch_b_next   = latch_b_reg;
        t1_count_next  = t1_count_reg;
        t1_reload_next = t1_reload_reg;
        t1_active_next = t1_active_reg;
        t2_count_next  = t2_count_reg;
        t2_reload_next = t2_reload_reg;
        t2_active_next = t2_active_reg;
        sr_next        = sr_reg;
        acr_next       = acr_reg;
        pcr_next       = pcr_reg;
        ifr_next       = ifr_reg;
        ier_next       = ier_reg;
        rd             = 8'h00;

        unique case (item.operation)
            OP_READ: begin
                unique case (item.reg_address)
                    REG_ORB: begin
                        ifr_next = ifr_reg & ~(FLAG_CB1 | FLAG_CB2);
                        rd = (orb_reg & ddrb_reg) | (pb_in & ~ddrb_reg);
                    end
                    REG_ORA: begin
                        ifr_next = ifr_reg & ~(FLAG_CA1 | FLAG_CA2);
                        rd = pa_val;
                    end
                    REG_DDRB: rd = ddrb_reg;
                    REG_DDRA: rd = ddra_reg;
                    REG_T1CL: begin
                        ifr_next = ifr_reg & ~FLAG_T1;
                        rd = t1_count_reg[7:0];
                    end
                    REG_T1CH: rd = t1_count_reg[15:8];
                    REG_T1LL: rd = t1_reload_reg[7:0];
                    REG_T1LH: rd = t1_reload_reg[15:8];
                    REG_T2CL: begin
                        ifr_next = ifr_reg & ~FLAG_T2;
                        rd = t2_count_reg[7:0];
                    end
                    REG_T2CH: rd = t2_count_reg[15:8];
                    REG_SR: begin
                        ifr_next = ifr_reg & ~FLAG_SR;
                        rd = sr_reg;
                    end
                    REG_ACR:    rd = acr_reg;
                    REG_PCR:    rd = pcr_reg;
                    REG_IFR:    rd = {|(ifr_reg & ier_reg), ifr_reg};
                    REG_IER:    rd = {1'b1, ier_reg};
                    REG_ORA_NH: rd = pa_val;
                endcase
            end
            OP_WRITE: begin
                unique case (item.reg_address)
                    REG_ORB: begin
                        ifr_next = ifr_reg & ~(FLAG_CB1 | FLAG_CB2);
                        orb_next = item.write_data;
                    end
                    REG_ORA: begin
                        ifr_next = ifr_reg & ~(FLAG_CA1 | FLAG_CA2);
                        ora_next = item.write_data;
                    end
                    REG_DDRB: ddrb_next = item.write_data;
                    REG_DDRA: ddra_next = item.write_data;
                    REG_T1CL, REG_T1LL: begin
                        t1_reload_next = {t1_reload_reg[15:8], item.write_data};
                    end
                    REG_T1CH: begin
                        // load high latch and start timer 1
                        t1_reload_next = {item.write_data, t1_reload_reg[7:0]};
                        t1_count_next  = {item.write_data, t1_reload_reg[7:0]};
                        t1_active_next = 1'b1;
                        ifr_next       = ifr_reg & ~FLAG_T1;
                        if (acr_reg[7]) begin
                            orb_next[7] = 1'b0;
                        end
                    end
                    REG_T1LH: begin
                        t1_reload_next = {item.write_data, t1_reload_reg[7:0]};
                        ifr_next       = ifr_reg & ~FLAG_T1;
                    end
                    REG_T2CL: begin
                        t2_reload_next = {t2_reload_reg[15:8], item.write_data};
                    end
                    REG_T2CH: begin
                        t2_reload_next = {item.write_data, t2_reload_reg[7:0]};
                        t2_count_next  = {item.write_data, t2_reload_reg[7:0]};
                        t2_active_next = 1'b1;
                        ifr_next       = ifr_reg & ~FLAG_T2;
                    end
                    REG_SR: begin
                        ifr_next = ifr_reg & ~FLAG_SR;
                        sr_next  = item.write_data;
                    end
                    REG_ACR: acr_next = item.write_data;
                    REG_PCR: pcr_next = item.write_data;
                    REG_IFR: ifr_next = ifr_reg & ~item.write_data[6:0];
                    REG_IER: begin
                        if (item.write_data[7]) begin
                            ier_next = ier_reg | item.write_data[6:0];
                        end else begin
                            ier_next = ier_reg & ~item.write_data[6:0];
                        end
                    end
                    REG_ORA_NH: ora_next = item.write_data;
                endcase
            end
            OP_TICK: begin
                if (t1_count_reg == 16'h0000) begin
                    if (t1_active_reg) begin
                        ifr_next = ifr_reg | FLAG_T1;
                        if (acr_reg[7]) begin
                            orb_next[7] = 1'b1;
                        end
                    end
                    if (acr_reg[6]) begin
                        t1_count_next = t1_reload_reg;
                    end else begin
                        t1_active_next = 1'b0;
                        t1_count_next  = 16'hffff;
                    end
                end else begin
                    t1_count_next = t1_count_reg - 16'd1;
                end
                if (t2_count_reg == 16'h0000) begin
                    if (t2_active_reg) begin
                        ifr_next = ifr_next | FLAG_T2;
                    end
                    t2_active_next = 1'b0;
                    t2_count_next  = 16'hffff;
                end else begin
                    t2_count_next = t2_count_reg - 16'd1;
                end
            end
            OP_CA1: begin
                ifr_next = ifr_reg | FLAG_CA1;
                if (acr_reg[0]) begin
                    latch_a_next = item.port_a_pins;
                end
            end
            OP_CB1: begin
                ifr_next = ifr_reg | FLAG_CB1;
                if (acr_reg[1]) begin
                    latch_b_next = item.port_b_pins;
                end
            end
            default: begin
            end
        endcase
    end

    assign result.read_data     = rd;
    assign result.port_a_drive  = ora_next;
    assign result.port_a_enable = ddra_next;
    assign result.port_b_drive  = orb_next;
    assign result.port_b_enable = ddrb_next;
    assign result.irq_out       = |(ifr_next & ier_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ora_reg       <= 8'h00;
            orb_reg       <= 8'h00;
            ddra_reg      <= 8'h00;
            ddrb_reg      <= 8'h00;
            latch_a_reg   <= 8'h00;
            latch_b_reg   <= 8'h00;
            t1_count_reg  <= 16'h0000;
            t1_reload_reg <= 16'h0000;
            t1_active_reg <= 1'b0;
            t2_count_reg  <= 16'h0000;
            t2_reload_reg <= 16'h0000;
            t2_active_reg <= 1'b0;
            sr_reg        <= 8'h00;
            acr_reg       <= 8'h00;
            pcr_reg       <= 8'h00;
            ifr_reg       <= 7'h00;
            ier_reg       <= 7'h00;
        end else if (ctrl.advance) begin
            ora_reg       <= ora_next;
            orb_reg       <= orb_next;
            ddra_reg      <= ddra_next;
            ddrb_reg      <= ddrb_next;
            latch_a_reg   <= latch_a_next;
            latch_b_reg   <= latch_b_next;
            t1_count_reg  <= t1_count_next;
            t1_reload_reg <= t1_reload_next;
            t1_active_reg <= t1_active_next;
            t2_count_reg  <= t2_count_next;
            t2_reload_reg <= t2_reload_next;
            t2_active_reg <= t2_active_next;
            sr_reg        <= sr_next;
            acr_reg       <= acr_next;
            pcr_reg       <= pcr_next;
            ifr_reg       <= ifr_next;
            ier_reg       <= ier_next;
        end
    end

`ifndef ASSERT_OFF
    a_t1_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && item.operation == OP_WRITE && item.reg_address == REG_T1CH
        |=> t1_active_reg && t1_count_reg == t1_reload_reg && !ifr_reg[6])
        else $error("timer 1 start did not load count and clear flag");

    a_t2_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && item.operation == OP_TICK && t2_count_reg == 16'h0000
        |=> !t2_active_reg && t2_count_reg == 16'hffff)
        else $error("timer 2 did not wrap after timeout");

    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.advance |=> $stable(ifr_reg) && $stable(t1_count_reg) && $stable(orb_reg))
        else $error("state changed without an accepted word");

    a_ca1_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance && item.operation == OP_CA1 |=> ifr_reg[1])
        else $error("CA1 edge did not set its flag");

    a_advance_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance |-> ctrl.valid)
        else $error("pipe advanced with no word held");
`endif

endmodule

`default_nettype wire

### hw/rtl/viar_out_stage.sv
`default_nettype none

module viar_out_stage (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              load,
    input  wire viar_pkg::result_t                 result,
    output logic                                   free,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_data[7:0], port_a_drive[15:8], port_a_enable[23:16],
    // port_b_drive[31:24], port_b_enable[39:32], irq_out[40]
    output logic [viar_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import viar_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, data_reg.irq_out, data_reg.port_b_enable,
                       data_reg.port_b_drive, data_reg.port_a_enable,
                       data_reg.port_a_drive, data_reg.read_data};

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/versatile_interface_adapter_regs_top.sv
// Register model of a two-port interface adapter with two timers.
// Input channel (s_*): one word per operation. s_tuser carries the
//   operation (read, write, timer tick, CA1 edge, CB1 edge); s_tdata
//   carries register address, write byte and the port A/B pin levels.
// Result channel (m_*): exactly one word per input word, in order:
//   read byte (zero unless a read), port A/B drive and direction values
//   and the interrupt line, all as they stand after the operation.
// Path: an accepted word is held in the input register; its result is loaded
//   into the result register once that is free, and then shows on m_tvalid.
// Throughput: one word per cycle unless m_tready stalls; each word's update is
//   a single pass of logic between the input and result registers.
// Stall: while m_tready is low the result register holds its word, one
//   more word waits in the input register, and then s_tready drops.
// Reset (aresetn low, synchronous): both pipe registers empty, all
//   adapter registers, timers, latches, flags and enables cleared.
`default_nettype none

module versatile_interface_adapter_regs_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // reg_address[3:0], write_data[11:4], port_a_pins[19:12],
    // port_b_pins[27:20], zero fill [31:28]
    input  wire logic [viar_pkg::IN_DATA_W-1:0]    s_tdata,
    // operation[2:0]
    input  wire logic [viar_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // read_data[7:0], port_a_drive[15:8], port_a_enable[23:16],
    // port_b_drive[31:24], port_b_enable[39:32], irq_out[40], zero fill [47:41]
    output logic [viar_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import viar_pkg::*;

    stage_ctrl_t ctrl;
    in_item_t    item;
    result_t     result;
    logic        out_free;

    // Hold the incoming word until the result register can take its result
    viar_in_stage u_in (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .downstream_free (out_free),
        .ctrl            (ctrl),
        .item            (item)
    );

    // Update the register file as the word advances
    viar_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .item    (item),
        .result  (result)
    );

    // Hold the result until the receiver takes it
    viar_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctrl.advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
